// ===== rtl/pairwise_distance_consistency_filter_top_defines.svh =====
// Assertion helpers shared by the filter RTL.
`ifndef PAIRWISE_DISTANCE_CONSISTENCY_FILTER_TOP_DEFINES_SVH
`define PAIRWISE_DISTANCE_CONSISTENCY_FILTER_TOP_DEFINES_SVH

// Plain implication checked on every clock edge outside reset.
`define PDCF_ASSERT_IMPL(lbl, pre, post) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (pre) |-> (post)) \
    else $error("pdcf assertion failed");

// Implication whose consequent is checked in the next cycle.
`define PDCF_ASSERT_NEXT(lbl, pre, post) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (pre) |=> (post)) \
    else $error("pdcf assertion failed");

`endif

// ===== rtl/pdcf_pkg.sv =====
package pdcf_pkg;

  localparam int unsigned CoordW = 16;
  localparam int unsigned MinW   = 6;
  localparam int unsigned TolW   = 16;
  localparam int unsigned KIdxW  = 6;
  localparam int unsigned RootW  = 17;
  localparam int unsigned RadW   = 2 * RootW;
  localparam int unsigned RemW   = RootW + 2;
  localparam int unsigned CfgIdxW = 8;

  localparam logic [CfgIdxW-1:0] REG_MIN_CONSISTENT   = 8'd0;
  localparam logic [CfgIdxW-1:0] REG_LENGTH_TOLERANCE = 8'd1;

  localparam logic [MinW-1:0] MIN_RESET = 6'd4;
  localparam logic [TolW-1:0] TOL_RESET = 16'd32;

  typedef struct packed {
    logic [CoordW-1:0] first_x;
    logic [CoordW-1:0] first_y;
    logic [CoordW-1:0] second_x;
    logic [CoordW-1:0] second_y;
    logic              final_pair;
  } pair_t;

  typedef struct packed {
    logic [KIdxW-1:0]  kept_index;
    logic [CoordW-1:0] kept_first_x;
    logic [CoordW-1:0] kept_first_y;
    logic [CoordW-1:0] kept_second_x;
    logic [CoordW-1:0] kept_second_y;
    logic              none_kept;
    logic              overflowed;
    logic              run_end;
  } result_t;

  typedef struct packed {
    logic [CoordW-1:0] first_x;
    logic [CoordW-1:0] first_y;
    logic [CoordW-1:0] second_x;
    logic [CoordW-1:0] second_y;
  } point_pair_t;

endpackage

// ===== rtl/pairwise_distance_consistency_filter_top.sv =====
// Pairwise distance consistency filter. Pairs are loaded one per cycle with
// start_i while busy_o is low; a pair with final_pair set starts evaluation and
// raises busy_o. Every stored pair i is compared with every other stored pair
// j by one shared 16x16 multiplier and one shared bit-serial square-root unit.
// Each (i,j) test reads pair j from the store, then for each image squares dx
// and dy on the multiplier and runs the root unit; the scan of pair i ends as
// soon as it has reached the minimum number of consistent partners. Results
// leave on res_o, each valid for exactly one cycle with res_valid_o high; the
// receiver cannot stall them, and every such cycle is one transfer. The last
// result of a set carries run_end, and busy_o is already low in that cycle.
// Configuration writes are always accepted (cfg_ready_o is tied high) and
// should only be issued while busy_o is low.
module pairwise_distance_consistency_filter_top #(
  parameter int unsigned MAX_POINTS = 64
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            start_i,
  output logic                            busy_o,
  input  pdcf_pkg::pair_t                 pair_i,
  output logic                            res_valid_o,
  output pdcf_pkg::result_t               res_o,
  input  logic                            cfg_valid_i,
  output logic                            cfg_ready_o,
  input  logic [pdcf_pkg::CfgIdxW-1:0]    cfg_index_i,
  input  logic [pdcf_pkg::TolW-1:0]       cfg_data_i
);
  import pdcf_pkg::*;

`include "pairwise_distance_consistency_filter_top_defines.svh"

  localparam int unsigned IdxW = (MAX_POINTS > 1) ? $clog2(MAX_POINTS) : 1;
  localparam int unsigned CntW = $clog2(MAX_POINTS + 1);
  localparam int unsigned StepW = $clog2(RootW + 1);

  // Sequencer codes.
  localparam logic [3:0] S_IDLE = 4'd0;
  localparam logic [3:0] S_RDI  = 4'd1;
  localparam logic [3:0] S_GETI = 4'd2;
  localparam logic [3:0] S_RDJ  = 4'd3;
  localparam logic [3:0] S_GETJ = 4'd4;
  localparam logic [3:0] S_SQX  = 4'd5;
  localparam logic [3:0] S_SQY  = 4'd6;
  localparam logic [3:0] S_ROOT = 4'd7;
  localparam logic [3:0] S_FIN  = 4'd8;

  logic [3:0] state_q, state_d;

  // Pair store: written during loading, read one address per cycle.
  point_pair_t mem [MAX_POINTS];
  point_pair_t rd_data_q;
  logic [IdxW-1:0] rd_addr;

  logic [CntW-1:0] count_q, count_d;
  logic            drop_q, drop_d;
  logic [MinW-1:0] min_q;
  logic [TolW-1:0] tol_q;

  logic [CntW-1:0] i_q, i_d, j_q, j_d;
  logic [MinW-1:0] cnt_q, cnt_d;
  point_pair_t     pi_q, pi_d, pj_q, pj_d;
  logic            side_q, side_d;

  logic [2*CoordW:0] acc_q, acc_d;
  logic [RadW-1:0]   rad_q, rad_d;
  logic [RemW-1:0]   rem_q, rem_d;
  logic [RootW-1:0]  root_q, root_d, d1_q, d1_d;
  logic [StepW-1:0]  step_q, step_d;

  logic            pend_v_q, pend_v_d;
  logic [CntW-1:0] pend_i_q, pend_i_d;
  point_pair_t     pend_p_q, pend_p_d;

  logic    res_valid_q, res_valid_d;
  result_t res_q, res_d;

  logic            accept;
  logic [CoordW-1:0] a_x, a_y, b_x, b_y, dx, dy, mul_op;
  logic [2*CoordW-1:0] prod;
  logic [RemW-1:0]   rem_sh, trial;
  logic [RootW-1:0]  root_nx, diff;
  logic [MinW-1:0]   need;
  logic [MinW:0]     cnt_inc;

  assign accept      = start_i && (state_q == S_IDLE);
  assign busy_o      = (state_q != S_IDLE);
  assign cfg_ready_o = 1'b1;
  assign res_valid_o = res_valid_q;
  assign res_o       = res_q;

  // Image one is used on the first pass of a test, image two on the second.
  assign a_x = side_q ? pi_q.second_x : pi_q.first_x;
  assign a_y = side_q ? pi_q.second_y : pi_q.first_y;
  assign b_x = side_q ? pj_q.second_x : pj_q.first_x;
  assign b_y = side_q ? pj_q.second_y : pj_q.first_y;
  assign dx  = (a_x > b_x) ? a_x - b_x : b_x - a_x;
  assign dy  = (a_y > b_y) ? a_y - b_y : b_y - a_y;

  // The single shared multiplier squares dx, then dy.
  assign mul_op = (state_q == S_SQX) ? dx : dy;
  assign prod   = mul_op * mul_op;

  // One restoring square-root digit per cycle.
  assign rem_sh  = {rem_q[RemW-3:0], rad_q[RadW-1 -: 2]};
  assign trial   = {root_q, 2'b01};
  assign root_nx = (rem_sh >= trial) ? {root_q[RootW-2:0], 1'b1} : {root_q[RootW-2:0], 1'b0};

  assign diff    = (d1_q > root_q) ? d1_q - root_q : root_q - d1_q;
  assign need    = (min_q == '0) ? MinW'(1) : min_q;
  assign cnt_inc = {1'b0, cnt_q} + (MinW+1)'(1);

  always_comb begin
    state_d     = state_q;
    count_d     = count_q;
    drop_d      = drop_q;
    i_d         = i_q;
    j_d         = j_q;
    cnt_d       = cnt_q;
    pi_d        = pi_q;
    pj_d        = pj_q;
    side_d      = side_q;
    acc_d       = acc_q;
    rad_d       = rad_q;
    rem_d       = rem_q;
    root_d      = root_q;
    d1_d        = d1_q;
    step_d      = step_q;
    pend_v_d    = pend_v_q;
    pend_i_d    = pend_i_q;
    pend_p_d    = pend_p_q;
    res_valid_d = 1'b0;
    res_d       = res_q;
    rd_addr     = i_q[IdxW-1:0];

    unique case (state_q)
      S_IDLE: begin
        if (accept) begin
          if (count_q < CntW'(MAX_POINTS)) begin
            count_d = count_q + CntW'(1);
          end else begin
            drop_d = 1'b1;
          end
          if (pair_i.final_pair) begin
            i_d      = '0;
            pend_v_d = 1'b0;
            state_d  = S_RDI;
          end
        end
      end
      S_RDI: begin
        rd_addr = i_q[IdxW-1:0];
        if (i_q == count_q) begin
          state_d = S_FIN;
        end else begin
          state_d = S_GETI;
        end
      end
      S_GETI: begin
        pi_d    = rd_data_q;
        j_d     = '0;
        cnt_d   = '0;
        state_d = S_RDJ;
      end
      S_RDJ: begin
        rd_addr = j_q[IdxW-1:0];
        if (j_q == count_q) begin
          i_d     = i_q + CntW'(1);
          state_d = S_RDI;
        end else if (j_q == i_q) begin
          j_d = j_q + CntW'(1);
        end else begin
          state_d = S_GETJ;
        end
      end
      S_GETJ: begin
        pj_d    = rd_data_q;
        side_d  = 1'b0;
        state_d = S_SQX;
      end
      S_SQX: begin
        acc_d   = {1'b0, prod};
        state_d = S_SQY;
      end
      S_SQY: begin
        rad_d   = RadW'(acc_q + {1'b0, prod});
        rem_d   = '0;
        root_d  = '0;
        step_d  = '0;
        state_d = S_ROOT;
      end
      S_ROOT: begin
        rem_d  = (rem_sh >= trial) ? rem_sh - trial : rem_sh;
        root_d = root_nx;
        rad_d  = {rad_q[RadW-3:0], 2'b00};
        step_d = step_q + StepW'(1);
        if (step_q == StepW'(RootW)) begin
          // The root is complete; hold its registers and consume it.
          rem_d  = rem_q;
          root_d = root_q;
          rad_d  = rad_q;
          if (!side_q) begin
            d1_d    = root_q;
            side_d  = 1'b1;
            state_d = S_SQX;
          end else if (TolW'(diff) <= tol_q && diff[RootW-1:TolW] == '0) begin
            cnt_d = cnt_inc[MinW-1:0];
            if (cnt_inc >= {1'b0, need}) begin
              if (pend_v_q) begin
                res_valid_d = 1'b1;
                res_d = '{kept_index: KIdxW'(pend_i_q), kept_first_x: pend_p_q.first_x,
                          kept_first_y: pend_p_q.first_y, kept_second_x: pend_p_q.second_x,
                          kept_second_y: pend_p_q.second_y, none_kept: 1'b0,
                          overflowed: drop_q, run_end: 1'b0};
              end
              pend_v_d = 1'b1;
              pend_i_d = i_q;
              pend_p_d = pi_q;
              i_d      = i_q + CntW'(1);
              state_d  = S_RDI;
            end else begin
              j_d     = j_q + CntW'(1);
              state_d = S_RDJ;
            end
          end else begin
            j_d     = j_q + CntW'(1);
            state_d = S_RDJ;
          end
        end
      end
      S_FIN: begin
        res_valid_d = 1'b1;
        if (pend_v_q) begin
          res_d = '{kept_index: KIdxW'(pend_i_q), kept_first_x: pend_p_q.first_x,
                    kept_first_y: pend_p_q.first_y, kept_second_x: pend_p_q.second_x,
                    kept_second_y: pend_p_q.second_y, none_kept: 1'b0,
                    overflowed: drop_q, run_end: 1'b1};
        end else begin
          res_d = '{kept_index: '0, kept_first_x: '0, kept_first_y: '0,
                    kept_second_x: '0, kept_second_y: '0, none_kept: 1'b1,
                    overflowed: drop_q, run_end: 1'b1};
        end
        pend_v_d = 1'b0;
        count_d  = '0;
        drop_d   = 1'b0;
        state_d  = S_IDLE;
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  // Store write on each accepted pair that fits; registered read port.
  always_ff @(posedge clk_i) begin
    if (accept && count_q < CntW'(MAX_POINTS)) begin
      mem[count_q[IdxW-1:0]] <= '{first_x: pair_i.first_x, first_y: pair_i.first_y,
                                  second_x: pair_i.second_x, second_y: pair_i.second_y};
    end
    rd_data_q <= mem[rd_addr];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      count_q     <= '0;
      drop_q      <= 1'b0;
      min_q       <= MIN_RESET;
      tol_q       <= TOL_RESET;
      pend_v_q    <= 1'b0;
      res_valid_q <= 1'b0;
      i_q         <= '0;
      j_q         <= '0;
      cnt_q       <= '0;
      side_q      <= 1'b0;
      step_q      <= '0;
    end else begin
      state_q     <= state_d;
      count_q     <= count_d;
      drop_q      <= drop_d;
      pend_v_q    <= pend_v_d;
      res_valid_q <= res_valid_d;
      i_q         <= i_d;
      j_q         <= j_d;
      cnt_q       <= cnt_d;
      side_q      <= side_d;
      step_q      <= step_d;
      if (cfg_valid_i) begin
        if (cfg_index_i == REG_MIN_CONSISTENT) begin
          min_q <= cfg_data_i[MinW-1:0];
        end else if (cfg_index_i == REG_LENGTH_TOLERANCE) begin
          tol_q <= cfg_data_i;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    pi_q     <= pi_d;
    pj_q     <= pj_d;
    acc_q    <= acc_d;
    rad_q    <= rad_d;
    rem_q    <= rem_d;
    root_q   <= root_d;
    d1_q     <= d1_d;
    pend_i_q <= pend_i_d;
    pend_p_q <= pend_p_d;
    res_q    <= res_d;
  end

  `PDCF_ASSERT_IMPL(a_res_while_busy, res_valid_o && !res_o.run_end, busy_o)
  `PDCF_ASSERT_IMPL(a_idle_at_end, res_valid_o && res_o.run_end, !busy_o)
  `PDCF_ASSERT_NEXT(a_load_stays_idle, accept && !pair_i.final_pair, !busy_o)
  `PDCF_ASSERT_IMPL(a_none_is_last, res_valid_o && res_o.none_kept, res_o.run_end)
  `PDCF_ASSERT_IMPL(a_count_bound, 1'b1, count_q <= CntW'(MAX_POINTS))

endmodule
